// ----- src/rgb_to_hsl_color_classifier_macros.svh -----
// assertion macros for the rgb to hsl colour classifier
`ifndef RGB_TO_HSL_COLOR_CLASSIFIER_MACROS_SVH
`define RGB_TO_HSL_COLOR_CLASSIFIER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define RTHCC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RTHCC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- src/rthcc_pkg.sv -----
// shared types and constants for the rgb to hsl colour classifier
`default_nettype none

package rthcc_pkg;

   // quotient width of both dividers, one cell per quotient bit
   localparam int unsigned QUO_BITS = 12;
   localparam int unsigned REM_BITS = 8;
   localparam int unsigned DVD_BITS = QUO_BITS + REM_BITS;

   // fixed point scales and hue sector offsets, 1/64 degree
   localparam logic [11:0] HUE_SCALE    = 12'd3840;
   localparam logic [11:0] SAT_SCALE    = 12'd4095;
   localparam logic [14:0] HUE_FULL     = 15'd23040;
   localparam logic [14:0] OFFSET_RED   = 15'd0;
   localparam logic [14:0] OFFSET_GREEN = 15'd7680;
   localparam logic [14:0] OFFSET_BLUE  = 15'd15360;

   // register indexes on the csr port
   localparam logic [2:0] REG_BLACK_LIMIT  = 3'd0;
   localparam logic [2:0] REG_WHITE_LIMIT  = 3'd1;
   localparam logic [2:0] REG_RED_LIMIT    = 3'd2;
   localparam logic [2:0] REG_YELLOW_LIMIT = 3'd3;
   localparam logic [2:0] REG_GREEN_LIMIT  = 3'd4;
   localparam logic [2:0] REG_BLUE_LIMIT   = 3'd5;

   // register reset values
   localparam logic [8:0]  RST_BLACK_LIMIT  = 9'd77;
   localparam logic [8:0]  RST_WHITE_LIMIT  = 9'd387;
   localparam logic [14:0] RST_RED_LIMIT    = 15'd1920;
   localparam logic [14:0] RST_YELLOW_LIMIT = 15'd5760;
   localparam logic [14:0] RST_GREEN_LIMIT  = 15'd9600;
   localparam logic [14:0] RST_BLUE_LIMIT   = 15'd17920;

   // colour class codes
   localparam logic [2:0] CLASS_BLACK  = 3'd0;
   localparam logic [2:0] CLASS_WHITE  = 3'd1;
   localparam logic [2:0] CLASS_RED    = 3'd2;
   localparam logic [2:0] CLASS_YELLOW = 3'd3;
   localparam logic [2:0] CLASS_GREEN  = 3'd4;
   localparam logic [2:0] CLASS_BLUE   = 3'd5;
   localparam logic [2:0] CLASS_NONE   = 3'd6;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one lane of a restoring divider, dividend bits shift out of lo
   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [QUO_BITS-1:0] lo;
      logic [QUO_BITS-1:0] quo;
      logic [REM_BITS-1:0] divisor;
   } div_type;

   // values carried alongside the dividers
   typedef struct packed {
      logic        grey;
      logic        neg;
      logic [14:0] offset;
      logic [8:0]  sum;
   } side_type;

   typedef struct packed {
      div_type  hue_div;
      div_type  sat_div;
      side_type side;
   } stage_type;

   typedef struct packed {
      logic [8:0]  black_limit;
      logic [8:0]  white_limit;
      logic [14:0] red_hue_limit;
      logic [14:0] yellow_hue_limit;
      logic [14:0] green_hue_limit;
      logic [14:0] blue_hue_limit;
   } cfg_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [11:0] saturation;
      logic [8:0]  lightness_sum;
      logic [2:0]  color_class;
   } result_type;

endpackage

`default_nettype wire

// ----- src/rthcc_front.sv -----
// first stage: channel extremes, sector, scaled dividends and divisors
`default_nettype none

module rthcc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire rthcc_pkg::pixel_type in_pixel,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output rthcc_pkg::stage_type     out_stage
);

   logic [7:0]  mx, mn, delta, denom, mag;
   logic [8:0]  sum, sum_comp;
   logic signed [8:0] diff;
   logic [14:0] offset;
   logic [rthcc_pkg::DVD_BITS-1:0] hue_dvd, sat_dvd;
   rthcc_pkg::stage_type stage_in;
   rthcc_pkg::stage_type stage_ff;
   logic valid_ff;

   // largest and smallest channel
   always_comb begin
      mx = (in_pixel.red > in_pixel.green) ? in_pixel.red : in_pixel.green;
      mx = (mx > in_pixel.blue) ? mx : in_pixel.blue;
      mn = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
      mn = (mn < in_pixel.blue) ? mn : in_pixel.blue;
      delta = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
   end

   // hue sector and signed channel difference
   always_comb begin
      if (in_pixel.red == mx) begin
         diff = $signed({1'b0, in_pixel.green}) - $signed({1'b0, in_pixel.blue});
         offset = rthcc_pkg::OFFSET_RED;
      end else if (in_pixel.green == mx) begin
         diff = $signed({1'b0, in_pixel.blue}) - $signed({1'b0, in_pixel.red});
         offset = rthcc_pkg::OFFSET_GREEN;
      end else begin
         diff = $signed({1'b0, in_pixel.red}) - $signed({1'b0, in_pixel.green});
         offset = rthcc_pkg::OFFSET_BLUE;
      end
      mag = diff[8] ? 8'(-diff) : diff[7:0];
   end

   // saturation divisor is the smaller of sum and 510 minus sum
   always_comb begin
      sum_comp = 9'd510 - sum;
      denom = (sum > 9'd255) ? sum_comp[7:0] : sum[7:0];
      hue_dvd = rthcc_pkg::DVD_BITS'(mag) * rthcc_pkg::DVD_BITS'(rthcc_pkg::HUE_SCALE);
      sat_dvd = rthcc_pkg::DVD_BITS'(delta) * rthcc_pkg::DVD_BITS'(rthcc_pkg::SAT_SCALE);
   end

   // pack the stage, top dividend bits start as the remainder
   always_comb begin
      stage_in.hue_div.rem     = hue_dvd[rthcc_pkg::DVD_BITS-1:rthcc_pkg::QUO_BITS];
      stage_in.hue_div.lo      = hue_dvd[rthcc_pkg::QUO_BITS-1:0];
      stage_in.hue_div.quo     = '0;
      stage_in.hue_div.divisor = delta;
      stage_in.sat_div.rem     = sat_dvd[rthcc_pkg::DVD_BITS-1:rthcc_pkg::QUO_BITS];
      stage_in.sat_div.lo      = sat_dvd[rthcc_pkg::QUO_BITS-1:0];
      stage_in.sat_div.quo     = '0;
      stage_in.sat_div.divisor = denom;
      stage_in.side.grey       = (delta == 8'd0);
      stage_in.side.neg        = diff[8];
      stage_in.side.offset     = offset;
      stage_in.side.sum        = sum;
   end

   assign in_ready = !valid_ff || out_ready;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// ----- src/rthcc_div_cell.sv -----
// one divider cell: one quotient bit for the hue and saturation lanes
`default_nettype none

module rthcc_div_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire rthcc_pkg::stage_type in_stage,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output rthcc_pkg::stage_type     out_stage
);

   rthcc_pkg::stage_type stage_in;
   rthcc_pkg::stage_type stage_ff;
   logic valid_ff;

   // restoring step: shift in one dividend bit, subtract when it fits
   function automatic rthcc_pkg::div_type div_step(input rthcc_pkg::div_type d);
      rthcc_pkg::div_type   r;
      logic [rthcc_pkg::REM_BITS:0] trial;
      logic [rthcc_pkg::REM_BITS:0] less;
      logic                 fits;
      trial = {d.rem, d.lo[rthcc_pkg::QUO_BITS-1]};
      less  = trial - {1'b0, d.divisor};
      fits  = (trial >= {1'b0, d.divisor});
      r.rem     = fits ? less[rthcc_pkg::REM_BITS-1:0] : trial[rthcc_pkg::REM_BITS-1:0];
      r.lo      = {d.lo[rthcc_pkg::QUO_BITS-2:0], 1'b0};
      r.quo     = {d.quo[rthcc_pkg::QUO_BITS-2:0], fits};
      r.divisor = d.divisor;
      return r;
   endfunction

   always_comb begin
      stage_in.hue_div = div_step(in_stage.hue_div);
      stage_in.sat_div = div_step(in_stage.sat_div);
      stage_in.side    = in_stage.side;
   end

   assign in_ready = !valid_ff || out_ready;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

// ----- src/rthcc_back.sv -----
// last stage: hue sector fix-up, grey forcing, classification, output register
`default_nettype none

module rthcc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rthcc_pkg::cfg_type   cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rthcc_pkg::stage_type in_stage,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output rthcc_pkg::result_type     out_result
);

   logic signed [15:0] q_signed;
   logic signed [15:0] hue_raw;
   logic signed [15:0] hue_wrap;
   logic [14:0] hue;
   logic [11:0] sat;
   logic [2:0]  cls;
   rthcc_pkg::result_type result_in;
   rthcc_pkg::result_type result_ff;
   logic valid_ff;

   // apply sign and sector offset, wrap negative hue once
   always_comb begin
      q_signed = $signed({4'b0, in_stage.hue_div.quo});
      hue_raw  = $signed({1'b0, in_stage.side.offset})
               + (in_stage.side.neg ? -q_signed : q_signed);
      hue_wrap = hue_raw + $signed({1'b0, rthcc_pkg::HUE_FULL});
      if (in_stage.side.grey) begin
         hue = '0;
         sat = '0;
      end else begin
         hue = hue_raw[15] ? hue_wrap[14:0] : hue_raw[14:0];
         sat = in_stage.sat_div.quo;
      end
   end

   // first matching test wins
   always_comb begin
      if (in_stage.side.sum < cfg.black_limit) begin
         cls = rthcc_pkg::CLASS_BLACK;
      end else if (in_stage.side.sum > cfg.white_limit) begin
         cls = rthcc_pkg::CLASS_WHITE;
      end else if (hue < cfg.red_hue_limit) begin
         cls = rthcc_pkg::CLASS_RED;
      end else if (hue < cfg.yellow_hue_limit) begin
         cls = rthcc_pkg::CLASS_YELLOW;
      end else if (hue < cfg.green_hue_limit) begin
         cls = rthcc_pkg::CLASS_GREEN;
      end else if (hue < cfg.blue_hue_limit) begin
         cls = rthcc_pkg::CLASS_BLUE;
      end else begin
         cls = rthcc_pkg::CLASS_NONE;
      end
   end

   always_comb begin
      result_in.hue           = hue;
      result_in.saturation    = sat;
      result_in.lightness_sum = in_stage.side.sum;
      result_in.color_class   = cls;
   end

   assign in_ready = !valid_ff || out_ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// ----- src/rgb_to_hsl_color_classifier.sv -----
// top level of the rgb to hsl colour classifier
//
// Pixels enter on the req_ stream, one beat per pixel, and each gives one
// beat on the rsp_ stream with hue (1/64 degree), saturation (4095 = one),
// max plus min channel and a colour class. Results leave in input order.
// An accepted req_ beat passes through one front stage, twelve divider cells
// (one quotient bit each, both divisions side by side) and one classify and
// output stage. Throughput is one pixel per clock; every stage is a register
// with its own valid, so a new pixel is taken in each cycle while the chain
// moves.
// When the receiver holds rsp_tready low, the output register keeps its beat
// and the stages behind it keep filling until all are full; req_tready then
// falls. Empty stages go on accepting, so bubbles are squeezed out.
// Reset clears all stage valids and loads the class limits with their
// defaults. The csr_ port writes a limit when csr_we is high; indexes past
// the last register are ignored. Limits are to be written only while no
// pixel is in flight.
`default_nettype none

module rgb_to_hsl_color_classifier (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // red, green, blue
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // hue, saturation, lightness_sum, color_class, zero pad
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

`include "rgb_to_hsl_color_classifier_macros.svh"

   localparam int unsigned NCELLS = rthcc_pkg::QUO_BITS;

   rthcc_pkg::cfg_type    cfg_ff;
   rthcc_pkg::pixel_type  pixel;
   rthcc_pkg::result_type result;
   rthcc_pkg::stage_type  chain_stage [NCELLS+1];
   logic                  chain_valid [NCELLS+1];
   logic                  chain_ready [NCELLS+1];

   // class limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.black_limit      <= rthcc_pkg::RST_BLACK_LIMIT;
         cfg_ff.white_limit      <= rthcc_pkg::RST_WHITE_LIMIT;
         cfg_ff.red_hue_limit    <= rthcc_pkg::RST_RED_LIMIT;
         cfg_ff.yellow_hue_limit <= rthcc_pkg::RST_YELLOW_LIMIT;
         cfg_ff.green_hue_limit  <= rthcc_pkg::RST_GREEN_LIMIT;
         cfg_ff.blue_hue_limit   <= rthcc_pkg::RST_BLUE_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            rthcc_pkg::REG_BLACK_LIMIT: begin
               cfg_ff.black_limit <= csr_wdata[8:0];
            end
            rthcc_pkg::REG_WHITE_LIMIT: begin
               cfg_ff.white_limit <= csr_wdata[8:0];
            end
            rthcc_pkg::REG_RED_LIMIT: begin
               cfg_ff.red_hue_limit <= csr_wdata;
            end
            rthcc_pkg::REG_YELLOW_LIMIT: begin
               cfg_ff.yellow_hue_limit <= csr_wdata;
            end
            rthcc_pkg::REG_GREEN_LIMIT: begin
               cfg_ff.green_hue_limit <= csr_wdata;
            end
            rthcc_pkg::REG_BLUE_LIMIT: begin
               cfg_ff.blue_hue_limit <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // unpack the pixel beat
   assign pixel.red   = req_tdata[7:0];
   assign pixel.green = req_tdata[15:8];
   assign pixel.blue  = req_tdata[23:16];

   rthcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (pixel),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_stage (chain_stage[0])
   );

   // divider cells, one quotient bit each
   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      rthcc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   rthcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (chain_valid[NCELLS]),
      .in_ready   (chain_ready[NCELLS]),
      .in_stage   (chain_stage[NCELLS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // pack the result beat
   assign rsp_tdata = {1'b0, result.color_class, result.lightness_sum,
                       result.saturation, result.hue};

   // checks
   `RTHCC_ASSERT_IMPLY(a_hue_range, rsp_tvalid, result.hue < rthcc_pkg::HUE_FULL, "hue out of range")
   `RTHCC_ASSERT_IMPLY(a_grey_hue, rsp_tvalid && (result.saturation == 12'd0), result.hue == 15'd0, "zero saturation with nonzero hue")
   `RTHCC_ASSERT_ALWAYS(a_sum_range, !rsp_tvalid || (result.lightness_sum <= 9'd510), "lightness sum out of range")

endmodule

`default_nettype wire

// ----- tb/sv/tb_rgb_to_hsl_color_classifier.sv -----
// self-checking testbench for the rgb to hsl colour classifier
`default_nettype none

module tb_rgb_to_hsl_color_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes past the last limit register, writes there must be dropped
   localparam logic [2:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [2:0] REG_SPARE_HIGH = 3'd7;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned HOLD_INTERVAL = 700;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // hue, saturation, lightness_sum, color_class, zero pad
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   // pixels waiting to be offered and results waiting to arrive
   logic [23:0]           pixel_backlog[$];
   rthcc_pkg::result_type pending_hsl[$];

   // shadow of the limit registers
   rthcc_pkg::cfg_type    limits;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned ready_wait = 0;
   int unsigned rsp_beats = 0;
   int unsigned next_long_hold = 500;
   bit          idle_enable = 1'b0;

   rgb_to_hsl_color_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // hue, saturation, lightness and class of one pixel beat
   function automatic rthcc_pkg::result_type predict_hsl(logic [23:0] beat);
      int r, g, b, mx, mn, delta, sum, diff, offset, q, denom, hue, sat;
      rthcc_pkg::result_type res;
      r = int'(beat[7:0]);
      g = int'(beat[15:8]);
      b = int'(beat[23:16]);
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      delta = mx - mn;
      sum = mx + mn;
      hue = 0;
      sat = 0;
      // grey pixels keep hue and saturation at zero
      if (delta > 0) begin
         // red wins ties, then green
         if (r == mx) begin
            diff = g - b;
            offset = int'(rthcc_pkg::OFFSET_RED);
         end else if (g == mx) begin
            diff = b - r;
            offset = int'(rthcc_pkg::OFFSET_GREEN);
         end else begin
            diff = r - g;
            offset = int'(rthcc_pkg::OFFSET_BLUE);
         end
         // truncate on the magnitude, then restore the sign
         q = (int'(rthcc_pkg::HUE_SCALE) * ((diff < 0) ? -diff : diff)) / delta;
         if (diff < 0) q = -q;
         hue = q + offset;
         if (hue < 0) hue = hue + int'(rthcc_pkg::HUE_FULL);
         denom = 255 - ((sum > 255) ? sum - 255 : 255 - sum);
         if (denom > 0) sat = (delta * int'(rthcc_pkg::SAT_SCALE)) / denom;
         if (sat > int'(rthcc_pkg::SAT_SCALE)) sat = int'(rthcc_pkg::SAT_SCALE);
      end
      // first matching test decides the class
      if (sum < int'(limits.black_limit))
         res.color_class = rthcc_pkg::CLASS_BLACK;
      else if (sum > int'(limits.white_limit))
         res.color_class = rthcc_pkg::CLASS_WHITE;
      else if (hue < int'(limits.red_hue_limit))
         res.color_class = rthcc_pkg::CLASS_RED;
      else if (hue < int'(limits.yellow_hue_limit))
         res.color_class = rthcc_pkg::CLASS_YELLOW;
      else if (hue < int'(limits.green_hue_limit))
         res.color_class = rthcc_pkg::CLASS_GREEN;
      else if (hue < int'(limits.blue_hue_limit))
         res.color_class = rthcc_pkg::CLASS_BLUE;
      else
         res.color_class = rthcc_pkg::CLASS_NONE;
      res.hue = hue[14:0];
      res.saturation = sat[11:0];
      res.lightness_sum = sum[8:0];
      return res;
   endfunction

   function automatic logic [23:0] pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {b, g, r};
   endfunction

   function automatic logic [7:0] extreme_channel();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   // uniform pixels half the time, else greys, ties or extreme channels
   function automatic logic [23:0] random_pixel();
      logic [7:0] r, g, b;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            g = r;
            b = r;
         end
         1: g = r;
         2: b = g;
         3: b = r;
         4: begin
            r = extreme_channel();
            g = extreme_channel();
            b = extreme_channel();
         end
         default: ;
      endcase
      return pack_pixel(r, g, b);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // request driver, predicts each beat as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) pending_hsl.push_back(predict_hsl(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pixel_backlog.pop_front();
               send_gap <= idle_enable ? pick_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with random stalls and a long hold every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_beats <= rsp_beats + 1;
         if (ready_wait != 0) begin
            ready_wait <= ready_wait - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_beats >= next_long_hold) begin
            next_long_hold <= next_long_hold + HOLD_INTERVAL;
            ready_wait <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            ready_wait <= pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response checker, field by field against the oldest prediction
   always @(posedge clock) begin
      rthcc_pkg::result_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.hue = rsp_tdata[14:0];
         seen.saturation = rsp_tdata[26:15];
         seen.lightness_sum = rsp_tdata[35:27];
         seen.color_class = rsp_tdata[38:36];
         if (pending_hsl.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            $display("%t: result beat with no pixel pending: %h", $time, rsp_tdata);
         end else begin
            want = pending_hsl.pop_front();
            if (seen.hue !== want.hue) begin
               mismatch_count = mismatch_count + 1;
               $display("%t: hue expected %0d actual %0d", $time, want.hue, seen.hue);
            end
            if (seen.saturation !== want.saturation) begin
               mismatch_count = mismatch_count + 1;
               $display("%t: saturation expected %0d actual %0d",
                        $time, want.saturation, seen.saturation);
            end
            if (seen.lightness_sum !== want.lightness_sum) begin
               mismatch_count = mismatch_count + 1;
               $display("%t: lightness_sum expected %0d actual %0d",
                        $time, want.lightness_sum, seen.lightness_sum);
            end
            if (seen.color_class !== want.color_class) begin
               mismatch_count = mismatch_count + 1;
               $display("%t: color_class expected %0d actual %0d",
                        $time, want.color_class, seen.color_class);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one register write, shadow follows with the same masking
   task automatic write_limit(input logic [2:0] index, input logic [14:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         rthcc_pkg::REG_BLACK_LIMIT:  limits.black_limit = value[8:0];
         rthcc_pkg::REG_WHITE_LIMIT:  limits.white_limit = value[8:0];
         rthcc_pkg::REG_RED_LIMIT:    limits.red_hue_limit = value;
         rthcc_pkg::REG_YELLOW_LIMIT: limits.yellow_hue_limit = value;
         rthcc_pkg::REG_GREEN_LIMIT:  limits.green_hue_limit = value;
         rthcc_pkg::REG_BLUE_LIMIT:   limits.blue_hue_limit = value;
         default: ;
      endcase
   endtask

   task automatic load_limits(input logic [14:0] black, input logic [14:0] white,
                              input logic [14:0] red, input logic [14:0] yellow,
                              input logic [14:0] green, input logic [14:0] blue);
      write_limit(rthcc_pkg::REG_BLACK_LIMIT, black);
      write_limit(rthcc_pkg::REG_WHITE_LIMIT, white);
      write_limit(rthcc_pkg::REG_RED_LIMIT, red);
      write_limit(rthcc_pkg::REG_YELLOW_LIMIT, yellow);
      write_limit(rthcc_pkg::REG_GREEN_LIMIT, green);
      write_limit(rthcc_pkg::REG_BLUE_LIMIT, blue);
   endtask

   // nothing queued, nothing offered, nothing outstanding; sampled mid-cycle
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || req_tvalid || pending_hsl.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic stream_random_pixels(input int unsigned count);
      repeat (count) pixel_backlog.push_back(random_pixel());
      wait_drained();
   endtask

   initial begin
      limits.black_limit = rthcc_pkg::RST_BLACK_LIMIT;
      limits.white_limit = rthcc_pkg::RST_WHITE_LIMIT;
      limits.red_hue_limit = rthcc_pkg::RST_RED_LIMIT;
      limits.yellow_hue_limit = rthcc_pkg::RST_YELLOW_LIMIT;
      limits.green_hue_limit = rthcc_pkg::RST_GREEN_LIMIT;
      limits.blue_hue_limit = rthcc_pkg::RST_BLUE_LIMIT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed pixels under the reset limits, back to back
      idle_enable = 1'b0;
      pixel_backlog.push_back(pack_pixel(8'd0, 8'd0, 8'd0));
      pixel_backlog.push_back(pack_pixel(8'd255, 8'd255, 8'd255));
      pixel_backlog.push_back(pack_pixel(8'd128, 8'd128, 8'd128));
      pixel_backlog.push_back(pack_pixel(8'd255, 8'd0, 8'd0));
      pixel_backlog.push_back(pack_pixel(8'd0, 8'd255, 8'd0));
      pixel_backlog.push_back(pack_pixel(8'd0, 8'd0, 8'd255));
      // ties on the maximum pick red first, then green
      pixel_backlog.push_back(pack_pixel(8'd255, 8'd255, 8'd0));
      pixel_backlog.push_back(pack_pixel(8'd0, 8'd255, 8'd255));
      pixel_backlog.push_back(pack_pixel(8'd255, 8'd0, 8'd255));
      // negative red sector hue wraps round, then tiny channel spreads
      pixel_backlog.push_back(pack_pixel(8'd255, 8'd0, 8'd1));
      pixel_backlog.push_back(pack_pixel(8'd1, 8'd0, 8'd0));
      pixel_backlog.push_back(pack_pixel(8'd1, 8'd0, 8'd2));
      pixel_backlog.push_back(pack_pixel(8'd0, 8'd1, 8'd0));
      // truncating divisions
      pixel_backlog.push_back(pack_pixel(8'd200, 8'd100, 8'd7));
      pixel_backlog.push_back(pack_pixel(8'd10, 8'd20, 8'd30));
      pixel_backlog.push_back(pack_pixel(8'd37, 8'd211, 8'd90));
      // one step off white with the smallest denominator, then the largest
      pixel_backlog.push_back(pack_pixel(8'd255, 8'd255, 8'd254));
      pixel_backlog.push_back(pack_pixel(8'd254, 8'd255, 8'd254));
      pixel_backlog.push_back(pack_pixel(8'd128, 8'd127, 8'd128));
      pixel_backlog.push_back(pack_pixel(8'd1, 8'd254, 8'd1));
      wait_drained();

      idle_enable = 1'b1;
      stream_random_pixels(250);

      // all limits zero, high bits of the narrow registers dropped
      load_limits(15'h7E00, 15'h7E00, 15'd0, 15'd0, 15'd0, 15'd0);
      write_limit(REG_SPARE_LOW, 15'h7FFF);
      stream_random_pixels(200);

      // everything black, hue limits above range
      idle_enable = 1'b0;
      load_limits(15'd511, 15'd511, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      write_limit(REG_SPARE_HIGH, 15'd0);
      stream_random_pixels(100);

      // lightness tests off, hue bands spread over the circle
      idle_enable = 1'b1;
      load_limits(15'd0, 15'd511, 15'd3840, 15'd7680, 15'd11520, 15'd19200);
      stream_random_pixels(400);

      // random limits, lightness limits over the full write width
      load_limits(15'($urandom), 15'($urandom),
                  15'($urandom_range(0, 23040)), 15'($urandom_range(0, 23040)),
                  15'($urandom_range(0, 23040)), 15'($urandom_range(0, 23040)));
      stream_random_pixels(400);

      idle_enable = 1'b0;
      load_limits(15'($urandom_range(0, 200)), 15'($urandom_range(300, 511)),
                  15'($urandom_range(0, 5000)), 15'($urandom_range(5000, 10000)),
                  15'($urandom_range(10000, 16000)), 15'd23040);
      stream_random_pixels(400);

      if (mismatch_count == 0 && pending_hsl.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
